// ----- rtl/lsli_pkg.sv -----
// lsli_pkg: item types, sequencer states and solve microcode for the
// least-squares line intersection block. no dependencies.

package lsli_pkg;

  // input item: one 3d line
  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic               last_line;
  } line_t;

  // result item: nearest point and flags
  typedef struct packed {
    logic signed [31:0] result_x;
    logic signed [31:0] result_y;
    logic signed [31:0] result_z;
    logic               singular;
    logic               saturated;
  } result_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LINE,
    ST_OP_LOAD,
    ST_OP_MUL,
    ST_STORE,
    ST_DET_ABS,
    ST_NUM_ABS,
    ST_DIV,
    ST_ROUND,
    ST_INC
  } state_e;

  // operand sources of the solve multiplier
  typedef enum logic [3:0] {
    SRC_A00, SRC_A11, SRC_A22, SRC_A01, SRC_A02, SRC_A12,
    SRC_C00, SRC_C01, SRC_C02, SRC_C11, SRC_C12, SRC_C22,
    SRC_Q0, SRC_Q1, SRC_Q2
  } src_e;

  // where a finished accumulation goes
  typedef enum logic [3:0] {
    DST_NONE,
    DST_C00, DST_C01, DST_C02, DST_C11, DST_C12, DST_C22,
    DST_DET,
    DST_NUM
  } dst_e;

  // one microcode word: acc = (clr ? 0 : acc) +/- mcand * mplr
  typedef struct packed {
    src_e mcand;
    src_e mplr;
    logic clr;
    logic sub;
    dst_e dst;
  } prog_t;

  // per-line step decode
  typedef struct packed {
    logic [1:0] ia;    // first direction index of d*d product
    logic [1:0] ib;    // second direction index
    logic [1:0] row;   // row of r*p product
    logic [1:0] col;   // column of r*p product
    logic [2:0] ridx;  // r element index: xx yy zz xy xz yz
  } step_t;

  localparam int OP_W     = 5;
  localparam int STEP_W   = 4;
  localparam int DD_STEPS = 6;
  localparam logic [STEP_W-1:0] STEP_LAST = 4'd15;
  localparam logic [OP_W-1:0]   OP_DET    = 5'd14;

  // solve program: cofactors, determinant, then three numerators
  function automatic prog_t prog(input logic [OP_W-1:0] op);
    prog_t p;
    p = '{SRC_A00, SRC_A00, 1'b0, 1'b0, DST_NONE};
    case (op)
      5'd0:  p = '{SRC_A11, SRC_A22, 1'b1, 1'b0, DST_NONE};
      5'd1:  p = '{SRC_A12, SRC_A12, 1'b0, 1'b1, DST_C00};
      5'd2:  p = '{SRC_A02, SRC_A12, 1'b1, 1'b0, DST_NONE};
      5'd3:  p = '{SRC_A01, SRC_A22, 1'b0, 1'b1, DST_C01};
      5'd4:  p = '{SRC_A01, SRC_A12, 1'b1, 1'b0, DST_NONE};
      5'd5:  p = '{SRC_A02, SRC_A11, 1'b0, 1'b1, DST_C02};
      5'd6:  p = '{SRC_A00, SRC_A22, 1'b1, 1'b0, DST_NONE};
      5'd7:  p = '{SRC_A02, SRC_A02, 1'b0, 1'b1, DST_C11};
      5'd8:  p = '{SRC_A01, SRC_A02, 1'b1, 1'b0, DST_NONE};
      5'd9:  p = '{SRC_A00, SRC_A12, 1'b0, 1'b1, DST_C12};
      5'd10: p = '{SRC_A00, SRC_A11, 1'b1, 1'b0, DST_NONE};
      5'd11: p = '{SRC_A01, SRC_A01, 1'b0, 1'b1, DST_C22};
      5'd12: p = '{SRC_C00, SRC_A00, 1'b1, 1'b0, DST_NONE};
      5'd13: p = '{SRC_C01, SRC_A01, 1'b0, 1'b0, DST_NONE};
      OP_DET: p = '{SRC_C02, SRC_A02, 1'b0, 1'b0, DST_DET};
      5'd15: p = '{SRC_C00, SRC_Q0,  1'b1, 1'b0, DST_NONE};
      5'd16: p = '{SRC_C01, SRC_Q1,  1'b0, 1'b0, DST_NONE};
      5'd17: p = '{SRC_C02, SRC_Q2,  1'b0, 1'b0, DST_NUM};
      5'd18: p = '{SRC_C01, SRC_Q0,  1'b1, 1'b0, DST_NONE};
      5'd19: p = '{SRC_C11, SRC_Q1,  1'b0, 1'b0, DST_NONE};
      5'd20: p = '{SRC_C12, SRC_Q2,  1'b0, 1'b0, DST_NUM};
      5'd21: p = '{SRC_C02, SRC_Q0,  1'b1, 1'b0, DST_NONE};
      5'd22: p = '{SRC_C12, SRC_Q1,  1'b0, 1'b0, DST_NONE};
      5'd23: p = '{SRC_C22, SRC_Q2,  1'b0, 1'b0, DST_NUM};
      default: p = '{SRC_A00, SRC_A00, 1'b0, 1'b0, DST_NONE};
    endcase
    return p;
  endfunction

  // line step decode: steps 0..5 form d*d, steps 6..14 form r*p
  function automatic step_t step_info(input logic [STEP_W-1:0] s);
    step_t t;
    t = '0;
    case (s)
      4'd0:  t = '{2'd0, 2'd0, 2'd0, 2'd0, 3'd0};
      4'd1:  t = '{2'd1, 2'd1, 2'd0, 2'd0, 3'd1};
      4'd2:  t = '{2'd2, 2'd2, 2'd0, 2'd0, 3'd2};
      4'd3:  t = '{2'd0, 2'd1, 2'd0, 2'd0, 3'd3};
      4'd4:  t = '{2'd0, 2'd2, 2'd0, 2'd0, 3'd4};
      4'd5:  t = '{2'd1, 2'd2, 2'd0, 2'd0, 3'd5};
      4'd6:  t = '{2'd0, 2'd0, 2'd0, 2'd0, 3'd0};
      4'd7:  t = '{2'd0, 2'd0, 2'd0, 2'd1, 3'd3};
      4'd8:  t = '{2'd0, 2'd0, 2'd0, 2'd2, 3'd4};
      4'd9:  t = '{2'd0, 2'd0, 2'd1, 2'd0, 3'd3};
      4'd10: t = '{2'd0, 2'd0, 2'd1, 2'd1, 3'd1};
      4'd11: t = '{2'd0, 2'd0, 2'd1, 2'd2, 3'd5};
      4'd12: t = '{2'd0, 2'd0, 2'd2, 2'd0, 3'd4};
      4'd13: t = '{2'd0, 2'd0, 2'd2, 2'd1, 3'd5};
      4'd14: t = '{2'd0, 2'd0, 2'd2, 2'd2, 3'd2};
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

// ----- rtl/least_squares_line_intersection.sv -----
// least_squares_line_intersection: accumulates lines and solves for the
// nearest point with one shared adder under a microcoded sequencer.
// depends on lsli_pkg.
//
// channel   dir  handshake              payload
// line      in   start_i high, busy_o low  line_i   (lsli_pkg::line_t)
// result    out  done_o, one cycle         result_o (lsli_pkg::result_t)
//
// a line holds busy_o for 15 products on the 32x32 multiplier,
// one product per cycle, plus a drain step.
// a last line then adds the solve: 24 shift-add products and three
// restoring divides, all on one BW-bit adder.
// lines past MAX_LINES are taken but not summed.
// reset clears all sums and the line count; the result side cannot stall.

module least_squares_line_intersection #(
  parameter int MAX_LINES = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  lsli_pkg::line_t   line_i,
  output logic              busy_o,
  output logic              done_o,
  output lsli_pkg::result_t result_o
);

  localparam int CNT_W  = $clog2(MAX_LINES + 1);
  localparam int LOG_N  = $clog2(MAX_LINES);
  localparam int SUM_W  = 32 + LOG_N;
  localparam int Q_W    = 36 + LOG_N;
  localparam int COF_W  = 2 * SUM_W + 1;
  localparam int DET_W  = SUM_W + COF_W + 1;
  localparam int NUM_W  = COF_W + Q_W + 30;
  localparam int BW     = NUM_W + 1;
  localparam int MB_W   = Q_W;
  localparam int MBC_W  = $clog2(MB_W);
  localparam int DVC_W  = $clog2(BW);
  localparam int FRAC_W = 28;

  lsli_pkg::state_e state_q, state_d;

  // control registers
  logic [lsli_pkg::STEP_W-1:0] step_q;
  logic [lsli_pkg::OP_W-1:0]   op_q;
  logic [MBC_W-1:0]            mcnt_q;
  logic [DVC_W-1:0]            dcnt_q;
  logic [1:0]                  coord_q;
  logic [CNT_W-1:0]            cnt_q;
  logic                        done_q;

  // accumulators
  logic signed [SUM_W-1:0] sum_diag_q [3];
  logic signed [SUM_W-1:0] sum_off_q  [3];
  logic signed [Q_W-1:0]   sumq_q     [3];

  // line datapath
  lsli_pkg::line_t    line_q;
  logic signed [63:0] prod_q;
  logic signed [31:0] r_q [6];
  logic signed [65:0] racc_q;

  // solve datapath
  logic [BW-1:0]           mcand_q;
  logic [MB_W-1:0]         mplr_q;
  logic [BW-1:0]           acc_q;
  logic signed [COF_W-1:0] cof_q [6];
  logic [DET_W-1:0]        det_mag_q;
  logic                    det_neg_q;
  logic                    num_neg_q;
  logic [BW-1:0]           num_q;
  logic [BW-1:0]           rem_q;
  logic                    rnd_q;
  lsli_pkg::result_t       out_q;

  logic                    in_take;
  logic                    can_sum;
  lsli_pkg::prog_t         pw;
  lsli_pkg::step_t         si_mul;
  lsli_pkg::step_t         si_use;
  logic [lsli_pkg::STEP_W-1:0] k_use;
  logic [BW-1:0]           mplr_src;

  logic signed [31:0] p_arr [3];
  logic signed [31:0] d_arr [3];
  logic signed [31:0] opa;
  logic signed [31:0] opb;
  logic signed [63:0] mul_res;
  logic signed [63:0] r_full;
  logic signed [65:0] racc_n;

  logic [BW-1:0] alu_x;
  logic [BW-1:0] alu_y;
  logic          alu_sub;
  logic [BW:0]   alu_sum;
  logic [BW-1:0] alu_res;
  logic          alu_ge;

  logic          mlast;
  logic          dlast;
  logic          acc_zero;
  logic          emit_sing;
  logic          emit_fin;
  logic          done_d;
  logic [BW-1:0] num_mag;

  logic [BW-1:0] qmag;
  logic          q_neg;
  logic          q_hi_zero;
  logic          q_sat;
  logic [31:0]   q_val;

  // operand fetch for the solve multiplier
  function automatic logic [BW-1:0] src_val(input lsli_pkg::src_e s);
    logic [BW-1:0] v;
    v = '0;
    case (s)
      lsli_pkg::SRC_A00: v = BW'(sum_diag_q[0]);
      lsli_pkg::SRC_A11: v = BW'(sum_diag_q[1]);
      lsli_pkg::SRC_A22: v = BW'(sum_diag_q[2]);
      lsli_pkg::SRC_A01: v = BW'(sum_off_q[0]);
      lsli_pkg::SRC_A02: v = BW'(sum_off_q[1]);
      lsli_pkg::SRC_A12: v = BW'(sum_off_q[2]);
      lsli_pkg::SRC_C00: v = BW'(cof_q[0]);
      lsli_pkg::SRC_C01: v = BW'(cof_q[1]);
      lsli_pkg::SRC_C02: v = BW'(cof_q[2]);
      lsli_pkg::SRC_C11: v = BW'(cof_q[3]);
      lsli_pkg::SRC_C12: v = BW'(cof_q[4]);
      lsli_pkg::SRC_C22: v = BW'(cof_q[5]);
      lsli_pkg::SRC_Q0:  v = BW'(sumq_q[0]);
      lsli_pkg::SRC_Q1:  v = BW'(sumq_q[1]);
      lsli_pkg::SRC_Q2:  v = BW'(sumq_q[2]);
      default:           v = '0;
    endcase
    return v;
  endfunction

  assign in_take  = start_i && !busy_o;
  assign can_sum  = cnt_q < CNT_W'(MAX_LINES);
  assign pw       = lsli_pkg::prog(op_q);
  assign si_mul   = lsli_pkg::step_info(step_q);
  assign k_use    = step_q - 4'd1;
  assign si_use   = lsli_pkg::step_info(k_use);
  assign mplr_src = src_val(pw.mplr);

  assign p_arr[0] = line_q.point_x;
  assign p_arr[1] = line_q.point_y;
  assign p_arr[2] = line_q.point_z;
  assign d_arr[0] = 32'(line_q.dir_x);
  assign d_arr[1] = 32'(line_q.dir_y);
  assign d_arr[2] = 32'(line_q.dir_z);

  // per-line multiplier: d*d first, then r*p
  always_comb begin
    if (step_q < 4'(lsli_pkg::DD_STEPS)) begin
      opa = d_arr[si_mul.ia];
      opb = d_arr[si_mul.ib];
    end else begin
      opa = r_q[si_mul.ridx];
      opb = p_arr[si_mul.col];
    end
    mul_res = opa * opb;
  end

  // consume the product registered at the previous step
  always_comb begin
    r_full = ((k_use < 4'd3) ? 64'sd268435456 : 64'sd0) - prod_q;
    racc_n = ((si_use.col == 2'd0) ? 66'sd0 : racc_q) + 66'(prod_q);
  end

  // shared adder
  always_comb begin
    alu_sum = {1'b0, alu_x} + {1'b0, alu_y ^ {BW{alu_sub}}} + (BW + 1)'(alu_sub);
    alu_res = alu_sum[BW-1:0];
    alu_ge  = alu_sum[BW];
  end

  assign mlast    = mcnt_q == MBC_W'(MB_W - 1);
  assign dlast    = dcnt_q == DVC_W'(BW - 1);
  assign acc_zero = acc_q == '0;
  assign num_mag  = num_neg_q ? alu_res : acc_q;

  // rounding increment and saturation of one coordinate
  always_comb begin
    qmag      = alu_res;
    q_neg     = (num_neg_q ^ det_neg_q) && (qmag != '0);
    q_hi_zero = qmag[BW-1:32] == '0;
    if (q_neg) begin
      q_sat = !q_hi_zero || (qmag[31] && (qmag[30:0] != '0));
    end else begin
      q_sat = !q_hi_zero || qmag[31];
    end
    if (q_sat) begin
      q_val = q_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      q_val = q_neg ? (32'd0 - qmag[31:0]) : qmag[31:0];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      lsli_pkg::ST_IDLE: begin
        if (start_i) begin
          if (can_sum) state_d = lsli_pkg::ST_LINE;
          else if (line_i.last_line) state_d = lsli_pkg::ST_OP_LOAD;
        end
      end
      lsli_pkg::ST_LINE: begin
        if (step_q == lsli_pkg::STEP_LAST) begin
          state_d = line_q.last_line ? lsli_pkg::ST_OP_LOAD : lsli_pkg::ST_IDLE;
        end
      end
      lsli_pkg::ST_OP_LOAD: state_d = lsli_pkg::ST_OP_MUL;
      lsli_pkg::ST_OP_MUL: begin
        if (mlast) state_d = lsli_pkg::ST_STORE;
      end
      lsli_pkg::ST_STORE: begin
        case (pw.dst)
          lsli_pkg::DST_DET: state_d = acc_zero ? lsli_pkg::ST_IDLE : lsli_pkg::ST_DET_ABS;
          lsli_pkg::DST_NUM: state_d = lsli_pkg::ST_NUM_ABS;
          default:           state_d = lsli_pkg::ST_OP_LOAD;
        endcase
      end
      lsli_pkg::ST_DET_ABS: state_d = lsli_pkg::ST_OP_LOAD;
      lsli_pkg::ST_NUM_ABS: state_d = lsli_pkg::ST_DIV;
      lsli_pkg::ST_DIV: begin
        if (dlast) state_d = lsli_pkg::ST_ROUND;
      end
      lsli_pkg::ST_ROUND: state_d = lsli_pkg::ST_INC;
      lsli_pkg::ST_INC: begin
        state_d = (coord_q == 2'd2) ? lsli_pkg::ST_IDLE : lsli_pkg::ST_OP_LOAD;
      end
      default: state_d = lsli_pkg::ST_IDLE;
    endcase
  end

  // outputs and adder control
  always_comb begin
    busy_o    = state_q != lsli_pkg::ST_IDLE;
    emit_sing = (state_q == lsli_pkg::ST_STORE) && (pw.dst == lsli_pkg::DST_DET) && acc_zero;
    emit_fin  = (state_q == lsli_pkg::ST_INC) && (coord_q == 2'd2);
    done_d    = emit_sing || emit_fin;
    alu_x     = '0;
    alu_y     = '0;
    alu_sub   = 1'b0;
    case (state_q)
      lsli_pkg::ST_OP_MUL: begin
        alu_x   = acc_q;
        alu_y   = mplr_q[0] ? mcand_q : '0;
        alu_sub = pw.sub ^ mlast;
      end
      lsli_pkg::ST_DET_ABS, lsli_pkg::ST_NUM_ABS: begin
        alu_y   = acc_q;
        alu_sub = 1'b1;
      end
      lsli_pkg::ST_DIV: begin
        alu_x   = {rem_q[BW-2:0], num_q[BW-1]};
        alu_y   = BW'(det_mag_q);
        alu_sub = 1'b1;
      end
      lsli_pkg::ST_ROUND: begin
        alu_x   = {rem_q[BW-2:0], 1'b0};
        alu_y   = BW'(det_mag_q);
        alu_sub = 1'b1;
      end
      lsli_pkg::ST_INC: begin
        alu_x = num_q;
        alu_y = BW'(rnd_q);
      end
      default: begin
        alu_x = '0;
      end
    endcase
  end

  assign done_o   = done_q;
  assign result_o = out_q;

  // control state and accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lsli_pkg::ST_IDLE;
      step_q  <= '0;
      op_q    <= '0;
      mcnt_q  <= '0;
      dcnt_q  <= '0;
      coord_q <= '0;
      cnt_q   <= '0;
      done_q  <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        sum_diag_q[i] <= '0;
        sum_off_q[i]  <= '0;
        sumq_q[i]     <= '0;
      end
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      if (in_take) begin
        step_q  <= '0;
        op_q    <= '0;
        coord_q <= '0;
      end
      // line accumulation steps
      if (state_q == lsli_pkg::ST_LINE) begin
        step_q <= step_q + 4'd1;
        if (step_q > 4'(lsli_pkg::DD_STEPS) && si_use.col == 2'd2) begin
          sumq_q[si_use.row] <= sumq_q[si_use.row] + Q_W'(racc_n >>> FRAC_W);
        end
        if (step_q == lsli_pkg::STEP_LAST) begin
          for (int i = 0; i < 3; i++) begin
            sum_diag_q[i] <= sum_diag_q[i] + SUM_W'(r_q[i]);
            sum_off_q[i]  <= sum_off_q[i] + SUM_W'(r_q[3 + i]);
          end
          cnt_q <= cnt_q + 1'b1;
        end
      end
      if (state_q == lsli_pkg::ST_OP_LOAD) mcnt_q <= '0;
      if (state_q == lsli_pkg::ST_OP_MUL) mcnt_q <= mcnt_q + 1'b1;
      if (state_q == lsli_pkg::ST_NUM_ABS) dcnt_q <= '0;
      if (state_q == lsli_pkg::ST_DIV) dcnt_q <= dcnt_q + 1'b1;
      // program counter
      if ((state_q == lsli_pkg::ST_STORE && pw.dst != lsli_pkg::DST_DET
           && pw.dst != lsli_pkg::DST_NUM)
          || state_q == lsli_pkg::ST_DET_ABS || state_q == lsli_pkg::ST_INC) begin
        op_q <= op_q + 1'b1;
      end
      if (state_q == lsli_pkg::ST_INC) coord_q <= coord_q + 2'd1;
      // clear after a result
      if (done_d) begin
        cnt_q <= '0;
        for (int i = 0; i < 3; i++) begin
          sum_diag_q[i] <= '0;
          sum_off_q[i]  <= '0;
          sumq_q[i]     <= '0;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      line_q          <= line_i;
      out_q.saturated <= 1'b0;
      out_q.singular  <= 1'b0;
    end
    // line products
    if (state_q == lsli_pkg::ST_LINE) begin
      if (step_q != lsli_pkg::STEP_LAST) prod_q <= mul_res;
      if (step_q != '0 && step_q <= 4'(lsli_pkg::DD_STEPS)) begin
        r_q[k_use[2:0]] <= r_full[31:0];
      end
      if (step_q > 4'(lsli_pkg::DD_STEPS)) racc_q <= racc_n;
    end
    // shift-add multiply
    if (state_q == lsli_pkg::ST_OP_LOAD) begin
      mcand_q <= src_val(pw.mcand);
      mplr_q  <= mplr_src[MB_W-1:0];
      if (pw.clr) acc_q <= '0;
    end
    if (state_q == lsli_pkg::ST_OP_MUL) begin
      acc_q   <= alu_res;
      mcand_q <= {mcand_q[BW-2:0], 1'b0};
      mplr_q  <= {1'b0, mplr_q[MB_W-1:1]};
    end
    // store a finished sum
    if (state_q == lsli_pkg::ST_STORE) begin
      case (pw.dst)
        lsli_pkg::DST_C00: cof_q[0] <= acc_q[COF_W-1:0];
        lsli_pkg::DST_C01: cof_q[1] <= acc_q[COF_W-1:0];
        lsli_pkg::DST_C02: cof_q[2] <= acc_q[COF_W-1:0];
        lsli_pkg::DST_C11: cof_q[3] <= acc_q[COF_W-1:0];
        lsli_pkg::DST_C12: cof_q[4] <= acc_q[COF_W-1:0];
        lsli_pkg::DST_C22: cof_q[5] <= acc_q[COF_W-1:0];
        lsli_pkg::DST_DET: begin
          det_neg_q <= acc_q[BW-1];
          if (acc_zero) begin
            out_q.result_x  <= '0;
            out_q.result_y  <= '0;
            out_q.result_z  <= '0;
            out_q.singular  <= 1'b1;
            out_q.saturated <= 1'b0;
          end
        end
        lsli_pkg::DST_NUM: num_neg_q <= acc_q[BW-1];
        default: begin
          rnd_q <= rnd_q;
        end
      endcase
    end
    if (state_q == lsli_pkg::ST_DET_ABS) begin
      det_mag_q <= det_neg_q ? alu_res[DET_W-1:0] : acc_q[DET_W-1:0];
    end
    // restoring divide of |num| * 2^28 by |det|
    if (state_q == lsli_pkg::ST_NUM_ABS) begin
      num_q <= {num_mag[BW-FRAC_W-1:0], {FRAC_W{1'b0}}};
      rem_q <= '0;
    end
    if (state_q == lsli_pkg::ST_DIV) begin
      rem_q <= alu_ge ? alu_res : alu_x;
      num_q <= {num_q[BW-2:0], alu_ge};
    end
    if (state_q == lsli_pkg::ST_ROUND) rnd_q <= alu_ge;
    if (state_q == lsli_pkg::ST_INC) begin
      case (coord_q)
        2'd0:    out_q.result_x <= q_val;
        2'd1:    out_q.result_y <= q_val;
        default: out_q.result_z <= q_val;
      endcase
      if (q_sat) out_q.saturated <= 1'b1;
    end
  end

  // a result only closes a busy period
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_o))
    else $error("result without a busy period");

  // singular results carry no point
  a_singular_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.singular) |->
      (result_o.result_x == '0 && result_o.result_y == '0 &&
       result_o.result_z == '0 && !result_o.saturated))
    else $error("singular result with nonzero point");

  // the line count stays within the limit
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_LINES))
    else $error("line count past limit");

  // sums are clear when a result goes out
  a_clear_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (cnt_q == '0 && sumq_q[0] == '0 && sum_diag_q[0] == '0))
    else $error("accumulators not cleared with result");

endmodule
